### rtl/core/snlc_pkg.sv
package snlc_pkg;

    localparam int SqrtSteps = 31;
    localparam int DivSteps  = 31;
    localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

    typedef enum logic [2:0] {
        K_ZERO,
        K_HPOS,
        K_HNEG,
        K_VPOS,
        K_VNEG,
        K_GEN,
        K_SHORT
    } t_kind;

    typedef struct packed {
        logic signed [29:0] sx;
        logic signed [29:0] sy;
        logic [30:0]        adx;
        logic [30:0]        ady;
        logic               ndx;
        logic               ndy;
        t_kind              kind;
    } t_side;

endpackage

### rtl/core/snlc_sqrt_cell.sv
module snlc_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  snlc_pkg::t_side    i_side,
    input  logic [61:0]        i_s,
    input  logic [32:0]        i_r,
    input  logic [30:0]        i_q,
    output logic               o_valid,
    input  logic               i_ready,
    output snlc_pkg::t_side    o_side,
    output logic [61:0]        o_s,
    output logic [32:0]        o_r,
    output logic [30:0]        o_q
);

    logic            r_valid;
    snlc_pkg::t_side r_side;
    logic [61:0]     r_s;
    logic [32:0]     r_r;
    logic [30:0]     r_q;
    logic [34:0]     w_rsh;
    logic [34:0]     w_t;
    logic            w_ge;
    logic [34:0]     w_diff;
    logic [32:0]     n_r;
    logic [30:0]     n_q;

    assign w_rsh  = {i_r, i_s[61:60]};
    assign w_t    = {2'b00, i_q, 2'b01};
    assign w_ge   = w_rsh >= w_t;
    assign w_diff = w_rsh - w_t;
    assign n_r    = w_ge ? w_diff[32:0] : w_rsh[32:0];
    assign n_q    = {i_q[29:0], w_ge};
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_side <= i_side;
            r_s    <= {i_s[59:0], 2'b00};
            r_r    <= n_r;
            r_q    <= n_q;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_s     = r_s;
    assign o_r     = r_r;
    assign o_q     = r_q;

endmodule

### rtl/core/snlc_div_cell.sv
module snlc_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  snlc_pkg::t_side    i_side,
    input  logic [30:0]        i_len,
    input  logic [30:0]        i_ra,
    input  logic [30:0]        i_rb,
    input  logic               i_nba,
    input  logic               i_nbb,
    input  logic [30:0]        i_qa,
    input  logic [30:0]        i_qb,
    output logic               o_valid,
    input  logic               i_ready,
    output snlc_pkg::t_side    o_side,
    output logic [30:0]        o_len,
    output logic [30:0]        o_ra,
    output logic [30:0]        o_rb,
    output logic [30:0]        o_qa,
    output logic [30:0]        o_qb
);

    logic            r_valid;
    snlc_pkg::t_side r_side;
    logic [30:0]     r_len;
    logic [30:0]     r_ra;
    logic [30:0]     r_rb;
    logic [30:0]     r_qa;
    logic [30:0]     r_qb;
    logic [31:0]     w_ta;
    logic [31:0]     w_tb;
    logic [31:0]     w_da;
    logic [31:0]     w_db;
    logic            w_gea;
    logic            w_geb;

    assign w_ta  = {i_ra, i_nba};
    assign w_tb  = {i_rb, i_nbb};
    assign w_gea = w_ta >= {1'b0, i_len};
    assign w_geb = w_tb >= {1'b0, i_len};
    assign w_da  = w_ta - {1'b0, i_len};
    assign w_db  = w_tb - {1'b0, i_len};
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_side <= i_side;
            r_len  <= i_len;
            r_ra   <= w_gea ? w_da[30:0] : w_ta[30:0];
            r_rb   <= w_geb ? w_db[30:0] : w_tb[30:0];
            r_qa   <= {i_qa[29:0], w_gea};
            r_qb   <= {i_qb[29:0], w_geb};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_len   = r_len;
    assign o_ra    = r_ra;
    assign o_rb    = r_rb;
    assign o_qa    = r_qa;
    assign o_qb    = r_qb;

endmodule

### rtl/core/segment_normalized_line_coeffs.sv
// Turns a segment into the unit-normal line a*x + b*y + c = 0. One word is
// accepted per clock unless stalled; results leave in order. Three front
// stages form the differences, squares and squared length, a chain of 31
// cells takes the integer square root one root bit per cell, 31 more divide
// both normal components one quotient bit per cell, and four tail stages
// form the offset term and the output word. Horizontal, vertical and
// coincident segments get exact coefficients; a general segment with squared
// length below min_length_sq gives zeros with line_valid low. The user writes
// the threshold via i_cfg_wr_en with no word in flight; it is not enforced.
module segment_normalized_line_coeffs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [60:0]   i_cfg_wr_data,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // source_x, source_y, target_x, target_y
    input  logic [119:0]  i_s_axis_tdata,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // coef_a, coef_b, coef_c, zero padding
    output logic [103:0]  o_m_axis_tdata,
    // line_valid
    output logic          o_m_axis_tuser
);

    localparam int NSq  = snlc_pkg::SqrtSteps;
    localparam int NDiv = snlc_pkg::DivSteps;

    logic [60:0] r_min_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= 61'd1;
        end else if (i_cfg_wr_en) begin
            r_min_len <= i_cfg_wr_data;
        end
    end

    logic signed [29:0] w_sx, w_sy, w_tx, w_ty;
    logic signed [30:0] w_dx, w_dy;
    snlc_pkg::t_side    n_side0;

    assign w_sx = i_s_axis_tdata[29:0];
    assign w_sy = i_s_axis_tdata[59:30];
    assign w_tx = i_s_axis_tdata[89:60];
    assign w_ty = i_s_axis_tdata[119:90];
    assign w_dx = {w_tx[29], w_tx} - {w_sx[29], w_sx};
    assign w_dy = {w_sy[29], w_sy} - {w_ty[29], w_ty};

    always_comb begin
        n_side0.sx  = w_sx;
        n_side0.sy  = w_sy;
        n_side0.ndx = w_dx[30];
        n_side0.ndy = w_dy[30];
        n_side0.adx = w_dx[30] ? 31'(-w_dx) : 31'(w_dx);
        n_side0.ady = w_dy[30] ? 31'(-w_dy) : 31'(w_dy);
        if (w_sy == w_ty) begin
            if (w_tx > w_sx) begin
                n_side0.kind = snlc_pkg::K_HPOS;
            end else if (w_tx < w_sx) begin
                n_side0.kind = snlc_pkg::K_HNEG;
            end else begin
                n_side0.kind = snlc_pkg::K_ZERO;
            end
        end else if (w_sx == w_tx) begin
            n_side0.kind = (w_ty > w_sy) ? snlc_pkg::K_VPOS : snlc_pkg::K_VNEG;
        end else begin
            n_side0.kind = snlc_pkg::K_GEN;
        end
    end

    // Front stages.
    logic [2:0]      r_fv;
    logic [2:0]      w_frdy;
    snlc_pkg::t_side r_side0, r_side1, r_side2;
    snlc_pkg::t_side n_side2;
    logic [61:0]     r_sqx, r_sqy, r_s;
    logic [61:0]     w_s;

    logic            sq_v   [NSq+1];
    logic            sq_rdy [NSq+1];
    snlc_pkg::t_side sq_side[NSq+1];
    logic [61:0]     sq_s   [NSq+1];
    logic [32:0]     sq_r   [NSq+1];
    logic [30:0]     sq_q   [NSq+1];

    assign w_frdy[2] = !r_fv[2] || sq_rdy[0];
    assign w_frdy[1] = !r_fv[1] || w_frdy[2];
    assign w_frdy[0] = !r_fv[0] || w_frdy[1];
    assign o_s_axis_tready = w_frdy[0];
    assign w_s = r_sqx + r_sqy;

    always_comb begin
        n_side2 = r_side1;
        if (r_side1.kind == snlc_pkg::K_GEN && w_s < {1'b0, r_min_len}) begin
            n_side2.kind = snlc_pkg::K_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 3'b000;
        end else begin
            if (w_frdy[0]) begin
                r_fv[0] <= i_s_axis_tvalid;
            end
            if (w_frdy[1]) begin
                r_fv[1] <= r_fv[0];
            end
            if (w_frdy[2]) begin
                r_fv[2] <= r_fv[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frdy[0] && i_s_axis_tvalid) begin
            r_side0 <= n_side0;
        end
        if (w_frdy[1] && r_fv[0]) begin
            r_side1 <= r_side0;
            r_sqx   <= 62'(r_side0.adx) * 62'(r_side0.adx);
            r_sqy   <= 62'(r_side0.ady) * 62'(r_side0.ady);
        end
        if (w_frdy[2] && r_fv[1]) begin
            r_side2 <= n_side2;
            r_s     <= w_s;
        end
    end

    // Square root chain.
    assign sq_v[0]    = r_fv[2];
    assign sq_side[0] = r_side2;
    assign sq_s[0]    = r_s;
    assign sq_r[0]    = '0;
    assign sq_q[0]    = '0;

    logic            dv_v   [NDiv+1];
    logic            dv_rdy [NDiv+1];
    snlc_pkg::t_side dv_side[NDiv+1];
    logic [30:0]     dv_len [NDiv+1];
    logic [30:0]     dv_ra  [NDiv+1];
    logic [30:0]     dv_rb  [NDiv+1];
    logic [30:0]     dv_qa  [NDiv+1];
    logic [30:0]     dv_qb  [NDiv+1];

    assign sq_rdy[NSq] = dv_rdy[0];

    for (genvar k = 0; k < NSq; k++) begin : g_sqrt
        snlc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .o_ready (sq_rdy[k]),
            .i_side  (sq_side[k]),
            .i_s     (sq_s[k]),
            .i_r     (sq_r[k]),
            .i_q     (sq_q[k]),
            .o_valid (sq_v[k+1]),
            .i_ready (sq_rdy[k+1]),
            .o_side  (sq_side[k+1]),
            .o_s     (sq_s[k+1]),
            .o_r     (sq_r[k+1]),
            .o_q     (sq_q[k+1])
        );
    end

    // Division chain; the numerator is the magnitude shifted up by 30 bits.
    assign dv_v[0]    = sq_v[NSq];
    assign dv_side[0] = sq_side[NSq];
    assign dv_len[0]  = sq_q[NSq];
    assign dv_ra[0]   = {1'b0, sq_side[NSq].ady[30:1]};
    assign dv_rb[0]   = {1'b0, sq_side[NSq].adx[30:1]};
    assign dv_qa[0]   = '0;
    assign dv_qb[0]   = '0;

    logic [3:0] w_trdy;
    logic [3:0] r_tv;

    assign dv_rdy[NDiv] = w_trdy[0];

    for (genvar k = 0; k < NDiv; k++) begin : g_div
        snlc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[k]),
            .o_ready (dv_rdy[k]),
            .i_side  (dv_side[k]),
            .i_len   (dv_len[k]),
            .i_ra    (dv_ra[k]),
            .i_rb    (dv_rb[k]),
            .i_nba   ((k == 0) ? dv_side[0].ady[0] : 1'b0),
            .i_nbb   ((k == 0) ? dv_side[0].adx[0] : 1'b0),
            .i_qa    (dv_qa[k]),
            .i_qb    (dv_qb[k]),
            .o_valid (dv_v[k+1]),
            .i_ready (dv_rdy[k+1]),
            .o_side  (dv_side[k+1]),
            .o_len   (dv_len[k+1]),
            .o_ra    (dv_ra[k+1]),
            .o_rb    (dv_rb[k+1]),
            .o_qa    (dv_qa[k+1]),
            .o_qb    (dv_qb[k+1])
        );
    end

    // Tail stages: signs, products, sum, output word.
    snlc_pkg::t_side    r_side_t1, r_side_t2, r_side_t3;
    logic signed [31:0] r_a1, r_b1, r_a2, r_b2, r_a3, r_b3;
    logic signed [61:0] r_pa, r_pb;
    logic signed [62:0] r_sum;
    logic signed [62:0] w_bias;
    logic signed [62:0] w_tr;
    logic signed [33:0] w_cgen;
    logic signed [31:0] n_oa, n_ob;
    logic signed [33:0] n_oc;
    logic               n_ok;
    logic signed [31:0] r_oa, r_ob;
    logic signed [33:0] r_oc;
    logic               r_ok;
    logic signed [31:0] w_qa, w_qb;

    assign w_trdy[3] = !r_tv[3] || i_m_axis_tready;
    assign w_trdy[2] = !r_tv[2] || w_trdy[3];
    assign w_trdy[1] = !r_tv[1] || w_trdy[2];
    assign w_trdy[0] = !r_tv[0] || w_trdy[1];

    assign w_qa = {1'b0, dv_qa[NDiv]};
    assign w_qb = {1'b0, dv_qb[NDiv]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 4'b0000;
        end else begin
            if (w_trdy[0]) begin
                r_tv[0] <= dv_v[NDiv];
            end
            if (w_trdy[1]) begin
                r_tv[1] <= r_tv[0];
            end
            if (w_trdy[2]) begin
                r_tv[2] <= r_tv[1];
            end
            if (w_trdy[3]) begin
                r_tv[3] <= r_tv[2];
            end
        end
    end

    assign w_bias = r_sum + (r_sum[62] ? 63'(snlc_pkg::OneQ30 - 32'sd1) : 63'sd0);
    assign w_tr   = w_bias >>> 30;
    assign w_cgen = -w_tr[33:0];

    always_comb begin
        n_oa = '0;
        n_ob = '0;
        n_oc = '0;
        n_ok = 1'b1;
        case (r_side_t3.kind)
            snlc_pkg::K_ZERO: begin
            end
            snlc_pkg::K_HPOS: begin
                n_ob = snlc_pkg::OneQ30;
                n_oc = -34'(r_side_t3.sy);
            end
            snlc_pkg::K_HNEG: begin
                n_ob = -snlc_pkg::OneQ30;
                n_oc = 34'(r_side_t3.sy);
            end
            snlc_pkg::K_VPOS: begin
                n_oa = -snlc_pkg::OneQ30;
                n_oc = 34'(r_side_t3.sx);
            end
            snlc_pkg::K_VNEG: begin
                n_oa = snlc_pkg::OneQ30;
                n_oc = -34'(r_side_t3.sx);
            end
            snlc_pkg::K_GEN: begin
                n_oa = r_a3;
                n_ob = r_b3;
                n_oc = w_cgen;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_trdy[0] && dv_v[NDiv]) begin
            r_side_t1 <= dv_side[NDiv];
            r_a1 <= dv_side[NDiv].ndy ? -w_qa : w_qa;
            r_b1 <= dv_side[NDiv].ndx ? -w_qb : w_qb;
        end
        if (w_trdy[1] && r_tv[0]) begin
            r_side_t2 <= r_side_t1;
            r_a2 <= r_a1;
            r_b2 <= r_b1;
            r_pa <= 62'(r_side_t1.sx) * 62'(r_a1);
            r_pb <= 62'(r_side_t1.sy) * 62'(r_b1);
        end
        if (w_trdy[2] && r_tv[1]) begin
            r_side_t3 <= r_side_t2;
            r_a3  <= r_a2;
            r_b3  <= r_b2;
            r_sum <= 63'(r_pa) + 63'(r_pb);
        end
        if (w_trdy[3] && r_tv[2]) begin
            r_oa <= n_oa;
            r_ob <= n_ob;
            r_oc <= n_oc;
            r_ok <= n_ok;
        end
    end

    assign o_m_axis_tvalid = r_tv[3];
    assign o_m_axis_tdata  = {6'b0, r_oc, r_ob, r_oa};
    assign o_m_axis_tuser  = r_ok;

endmodule
